>>> rtl/arep_pkg.sv
// Shared types, codes and patch functions for the relocation entry patcher.
package arep_pkg;

  localparam int MaxSegmentsDef = 8;
  localparam int QueueDepthDef  = 4;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int SegW     = 4;
  localparam int CodeW    = 8;
  localparam int DistW    = 4;
  localparam int WordW    = 32;
  localparam int StatusW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEG_COUNT = 3'd0,
    REG_PAIR_A    = 3'd1,
    REG_PAIR_B    = 3'd2,
    REG_PAIR_C    = 3'd3,
    REG_PAIR_D    = 3'd4
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TYPE   = 2'd1,
    ST_BAD_FORMAT = 2'd2
  } status_e;

  localparam logic [CodeW-1:0] CodeNone    = 8'd0;
  localparam logic [CodeW-1:0] CodeAbs32   = 8'd2;
  localparam logic [CodeW-1:0] CodeThmCall = 8'd10;
  localparam logic [CodeW-1:0] CodeTarget1 = 8'd38;
  localparam logic [CodeW-1:0] CodePrel31  = 8'd42;
  localparam logic [CodeW-1:0] CodeMovwAbs = 8'd47;
  localparam logic [CodeW-1:0] CodeMovtAbs = 8'd48;

  localparam logic [SegW-1:0]  FormatZero  = 4'd0;

  localparam logic [WordW-1:0] Prel31Mask   = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] MovKeepMask  = 32'h8F00_FBF0;
  localparam logic [WordW-1:0] CallKeepMask = 32'hD000_F800;

  typedef enum logic [2:0] {
    K_ABS,
    K_PREL31,
    K_CALL,
    K_MOVW,
    K_MOVT,
    K_BAD
  } kind_e;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  // One classified entry, waiting for the back end.
  typedef struct packed {
    logic              fmt_bad;
    kind_e             kind1;
    kind_e             kind2;
    logic              has_second;
    logic [WordW-1:0]  sa;
    logic [WordW-1:0]  p1;
    logic [WordW-1:0]  p2;
    logic [WordW-1:0]  d1;
    logic [WordW-1:0]  old1;
    logic [WordW-1:0]  old2;
  } entry_t;

  function automatic kind_e classify(input logic [CodeW-1:0] code);
    kind_e k;
    unique case (code) inside
      CodeAbs32, CodeTarget1: k = K_ABS;
      CodePrel31:             k = K_PREL31;
      CodeThmCall:            k = K_CALL;
      CodeMovwAbs:            k = K_MOVW;
      CodeMovtAbs:            k = K_MOVT;
      default:                k = K_BAD;
    endcase
    return k;
  endfunction

  // MOVW/MOVT immediate: imm4 in [3:0], i in [10], imm3 in [30:28], imm8 in [23:16].
  function automatic logic [WordW-1:0] thumb_imm16(input logic [WordW-1:0] old,
                                                   input logic [15:0] v);
    logic [WordW-1:0] w;
    w = old & MovKeepMask;
    w[23:16] = v[7:0];
    w[30:28] = v[10:8];
    w[10]    = v[11];
    w[3:0]   = v[15:12];
    return w;
  endfunction

  // Thumb BL: imm10 and S in the first halfword, imm11, J1, J2 in the second.
  function automatic logic [WordW-1:0] thumb_call(input logic [WordW-1:0] old,
                                                  input logic [WordW-1:0] d);
    logic [WordW-1:0] w;
    logic             sgn;
    sgn = d[24];
    w = old & CallKeepMask;
    w[9:0]   = d[21:12];
    w[10]    = sgn;
    w[26:16] = d[11:1];
    w[27]    = sgn ^ ~d[22];
    w[29]    = sgn ^ ~d[23];
    return w;
  endfunction

  function automatic logic [WordW-1:0] patch(input kind_e kind,
                                             input logic [WordW-1:0] sa,
                                             input logic [WordW-1:0] d,
                                             input logic [WordW-1:0] old);
    logic [WordW-1:0] w;
    unique case (kind)
      K_ABS:    w = sa;
      K_PREL31: w = d & Prel31Mask;
      K_CALL:   w = thumb_call(old, d);
      K_MOVW:   w = thumb_imm16(old, sa[15:0]);
      K_MOVT:   w = thumb_imm16(old, sa[31:16]);
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/arep_if.sv
// Channel interfaces: relocation entries in, patched words out, register writes.
interface arep_in_if;
  import arep_pkg::*;
  logic               valid;
  logic               ready;
  logic [SegW-1:0]    entry_format;
  logic [SegW-1:0]    symbol_seg;
  logic [CodeW-1:0]   first_code;
  logic [SegW-1:0]    patch_seg;
  logic [CodeW-1:0]   second_code;
  logic [DistW-1:0]   second_distance;
  logic [WordW-1:0]   addend_value;
  logic [WordW-1:0]   patch_offset;
  logic [WordW-1:0]   first_old_word;
  logic [WordW-1:0]   second_old_word;

  modport source (
    output valid, entry_format, symbol_seg, first_code, patch_seg, second_code,
           second_distance, addend_value, patch_offset, first_old_word, second_old_word,
    input  ready
  );
  modport sink (
    input  valid, entry_format, symbol_seg, first_code, patch_seg, second_code,
           second_distance, addend_value, patch_offset, first_old_word, second_old_word,
    output ready
  );
endinterface

interface arep_out_if;
  import arep_pkg::*;
  logic               valid;
  logic               ready;
  logic [WordW-1:0]   target_address;
  logic [WordW-1:0]   new_word;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, target_address, new_word, status, last, input ready);
  modport sink (input valid, target_address, new_word, status, last, output ready);
endinterface

interface arep_cfg_if;
  import arep_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/arep_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arep_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/arep_front.sv
// Front end: segment table, entry acceptance, address math and classification.
module arep_front #(
  parameter int MAX_SEGMENTS = arep_pkg::MaxSegmentsDef,
  parameter int QUEUE_DEPTH  = arep_pkg::QueueDepthDef,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  arep_cfg_if.sink        cfg_i,
  arep_in_if.sink         in_i,
  input  logic [CntW-1:0] q_count_i,
  output logic            push_o,
  output arep_pkg::entry_t push_data_o
);
  import arep_pkg::*;

  localparam int PairCount = (MAX_SEGMENTS + 1) / 2;
  localparam int PairIdxW  = (PairCount > 1) ? $clog2(PairCount) : 1;
  localparam logic [SegW-1:0] MaxSegs = SegW'(MAX_SEGMENTS);

  typedef struct packed {
    logic              fmt_bad;
    logic              sym_use;
    logic              sym_hi;
    logic              pat_ok;
    logic              pat_use;
    logic              pat_hi;
    kind_e             kind1;
    kind_e             kind2;
    logic              has_second;
    logic [DistW-1:0]  place_gap;
    logic [WordW-1:0]  addend;
    logic [WordW-1:0]  offset;
    logic [WordW-1:0]  old1;
    logic [WordW-1:0]  old2;
  } stage_a_t;

  typedef struct packed {
    logic              fmt_bad;
    kind_e             kind1;
    kind_e             kind2;
    logic              has_second;
    logic [DistW-1:0]  place_gap;
    logic [WordW-1:0]  sa;
    logic [WordW-1:0]  p;
    logic [WordW-1:0]  old1;
    logic [WordW-1:0]  old2;
  } stage_b_t;

  logic [SegW-1:0]      seg_count_q;
  logic [PairCount-1:0] pair_valid_q;
  logic                 pair_we;
  logic [1:0]           cfg_pair;
  logic [SegW-1:0]      count_eff;

  logic [PairIdxW-1:0]  sym_raddr;
  logic [PairIdxW-1:0]  pat_raddr;
  logic [CfgDataW-1:0]  sym_rdata;
  logic [CfgDataW-1:0]  pat_rdata;

  logic                 in_acc;
  logic                 sym_ok;
  logic                 pat_ok;
  logic [CntW:0]        occupied;

  logic                 a_valid_q;
  stage_a_t             a_q;
  logic                 b_valid_q;
  stage_b_t             b_q;

  logic [WordW-1:0]     sym_word;
  logic [WordW-1:0]     pat_word;
  logic [WordW-1:0]     s_val;
  logic [WordW-1:0]     p_val;

  // Register writes: the count lives in flops, base pairs go into the RAMs.
  assign cfg_i.ready = 1'b1;
  assign cfg_pair    = 2'(cfg_i.index - REG_PAIR_A);

  always_comb begin
    pair_we = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_i.index) inside
        REG_PAIR_A, REG_PAIR_B, REG_PAIR_C, REG_PAIR_D: begin
          pair_we = (32'(cfg_pair) < PairCount);
        end
        default: pair_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q  <= '0;
      pair_valid_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.index == REG_SEG_COUNT) begin
        seg_count_q <= cfg_i.data[SegW-1:0];
      end
      if (pair_we) begin
        pair_valid_q[cfg_pair[PairIdxW-1:0]] <= 1'b1;
      end
    end
  end

  assign count_eff = (seg_count_q > MaxSegs) ? MaxSegs : seg_count_q;

  assign sym_raddr = in_i.symbol_seg[PairIdxW:1];
  assign pat_raddr = in_i.patch_seg[PairIdxW:1];

  arep_ram #(
    .WIDTH (CfgDataW),
    .DEPTH (PairCount)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (cfg_pair[PairIdxW-1:0]),
    .wdata_i (cfg_i.data),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  arep_ram #(
    .WIDTH (CfgDataW),
    .DEPTH (PairCount)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (cfg_pair[PairIdxW-1:0]),
    .wdata_i (cfg_i.data),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // Credit check: every item in flight must find a queue slot.
  assign occupied = (CntW+1)'(q_count_i) + (CntW+1)'(a_valid_q) + (CntW+1)'(b_valid_q);
  assign in_i.ready = (occupied < (CntW+1)'(QUEUE_DEPTH));
  assign in_acc     = in_i.valid && in_i.ready;

  assign sym_ok = (in_i.symbol_seg < count_eff);
  assign pat_ok = (in_i.patch_seg < count_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_acc;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q.fmt_bad    <= (in_i.entry_format != FormatZero);
      a_q.sym_use    <= sym_ok && pair_valid_q[sym_raddr];
      a_q.sym_hi     <= in_i.symbol_seg[0];
      a_q.pat_ok     <= pat_ok;
      a_q.pat_use    <= pat_ok && pair_valid_q[pat_raddr];
      a_q.pat_hi     <= in_i.patch_seg[0];
      a_q.kind1      <= classify(in_i.first_code);
      a_q.kind2      <= classify(in_i.second_code);
      a_q.has_second <= (in_i.second_code != CodeNone);
      a_q.place_gap  <= in_i.second_distance;
      a_q.addend     <= in_i.addend_value;
      a_q.offset     <= in_i.patch_offset;
      a_q.old1       <= in_i.first_old_word;
      a_q.old2       <= in_i.second_old_word;
    end
  end

  // Stage A: base words arrive from the RAMs; form S+A and P.
  assign sym_word = a_q.sym_hi ? sym_rdata[63:32] : sym_rdata[31:0];
  assign pat_word = a_q.pat_hi ? pat_rdata[63:32] : pat_rdata[31:0];
  assign s_val    = a_q.sym_use ? sym_word : '0;
  assign p_val    = a_q.pat_use ? pat_word : '0;

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_q.fmt_bad    <= a_q.fmt_bad;
      b_q.kind1      <= a_q.kind1;
      b_q.kind2      <= a_q.kind2;
      b_q.has_second <= a_q.has_second;
      b_q.place_gap  <= a_q.place_gap;
      b_q.sa         <= s_val + a_q.addend;
      b_q.p          <= a_q.pat_ok ? (p_val + a_q.offset) : '0;
      b_q.old1       <= a_q.old1;
      b_q.old2       <= a_q.old2;
    end
  end

  // Stage B: relative distance for the first place and the second address.
  assign push_o = b_valid_q;

  always_comb begin
    push_data_o.fmt_bad    = b_q.fmt_bad;
    push_data_o.kind1      = b_q.kind1;
    push_data_o.kind2      = b_q.kind2;
    push_data_o.has_second = b_q.has_second;
    push_data_o.sa         = b_q.sa;
    push_data_o.p1         = b_q.p;
    push_data_o.p2         = b_q.p + WordW'({b_q.place_gap, 1'b0});
    push_data_o.d1         = b_q.sa - b_q.p;
    push_data_o.old1       = b_q.old1;
    push_data_o.old2       = b_q.old2;
  end

endmodule

>>> rtl/arep_queue.sv
// Short FIFO of classified entries between the front and back ends.
module arep_queue #(
  parameter int DEPTH = arep_pkg::QueueDepthDef,
  localparam int CntW = $clog2(DEPTH + 1),
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  arep_pkg::entry_t push_data_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output arep_pkg::entry_t head_o,
  output logic [CntW-1:0]  count_o
);
  import arep_pkg::*;

  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign count_o      = count_q;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/arep_back.sv
// Back end: emits one or two patched-word beats per entry from the queue head.
module arep_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  arep_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             second_o,
  arep_out_if.source       out_o
);
  import arep_pkg::*;

  phase_e            state_q;
  phase_e            state_d;
  logic              load;
  logic [WordW-1:0]  d2;

  logic              out_valid_q;
  logic [WordW-1:0]  addr_q;
  logic [WordW-1:0]  word_q;
  status_e           status_q;
  logic              last_q;

  logic [WordW-1:0]  addr_d;
  logic [WordW-1:0]  word_d;
  status_e           status_d;
  logic              last_d;

  assign load = head_valid_i && (!out_valid_q || out_o.ready);
  assign d2   = head_i.sa - head_i.p2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    addr_d   = head_i.p1;
    word_d   = '0;
    status_d = ST_OK;
    last_d   = 1'b1;
    unique case (state_q)
      PH_FIRST: begin
        if (head_i.fmt_bad) begin
          addr_d   = '0;
          status_d = ST_BAD_FORMAT;
          pop_o    = load;
        end else if (head_i.kind1 == K_BAD) begin
          status_d = ST_BAD_TYPE;
          pop_o    = load;
        end else begin
          word_d = patch(head_i.kind1, head_i.sa, head_i.d1, head_i.old1);
          last_d = !head_i.has_second;
          if (load) begin
            if (head_i.has_second) begin
              state_d = PH_SECOND;
            end else begin
              pop_o = 1'b1;
            end
          end
        end
      end
      PH_SECOND: begin
        addr_d   = head_i.p2;
        word_d   = patch(head_i.kind2, head_i.sa, d2, head_i.old2);
        status_d = (head_i.kind2 == K_BAD) ? ST_BAD_TYPE : ST_OK;
        if (load) begin
          pop_o   = 1'b1;
          state_d = PH_FIRST;
        end
      end
      default: state_d = PH_FIRST;
    endcase
  end

  // Output register: hold the beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q   <= addr_d;
      word_q   <= word_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.target_address = addr_q;
  assign out_o.new_word       = word_q;
  assign out_o.status         = status_q;
  assign out_o.last           = last_q;
  assign second_o             = (state_q == PH_SECOND);

endmodule

>>> rtl/arm_relocation_entry_patcher.sv
// Top level of the ARM relocation entry patcher.
//
// Usage: software loads the segment table through cfg_i (index 0 is the
// valid segment count, indexes 1..4 are base pairs: low word is the even
// segment, high word the odd one). Write it only while the block is idle.
// Each beat on in_i is one format-0 relocation entry with the current
// words at its patch places; out_o returns the patched words with their
// addresses, one beat per place, last set on the final beat of an entry.
// An unknown format or first code gives a single error beat with last set.
//
// The first result beat of an entry passes through the segment RAM read,
// the address adds, the queue and the output register.
// Throughput: one entry per cycle for single-place entries while out_o is
// ready; an entry with a second place adds a beat on the result channel.
//
// Reset clears the segment count and base valid bits (every segment reads
// as invalid, unwritten bases read as zero), empties the queue and drops
// out_o.valid. When the sink stalls, the output register holds its beat,
// the queue fills, and in_i.ready falls once queued plus in-flight entries
// reach the queue depth.
module arm_relocation_entry_patcher #(
  parameter int MAX_SEGMENTS = arep_pkg::MaxSegmentsDef,
  parameter int QUEUE_DEPTH  = arep_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arep_cfg_if.sink    cfg_i,
  arep_in_if.sink     in_i,
  arep_out_if.source  out_o
);
  import arep_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic            push;
  entry_t          push_data;
  logic            pop;
  logic            head_valid;
  entry_t          head;
  logic [CntW-1:0] q_count;
  logic            second_pending;

  // Front end: accept, look up bases, compute S+A, P, P2 and classify codes.
  arep_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .in_i        (in_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue: the front never pushes without a free slot.
  arep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  // Back end: patch words and drive one beat per place.
  arep_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .second_o     (second_pending),
    .out_o        (out_o)
  );

`ifndef SYNTH
  // The credit check keeps a slot free for every entry in the pipeline.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count < CntW'(QUEUE_DEPTH)))
    else $error("queue push while full");

  // The second place is only worked on while its entry sits at the head.
  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_pending |-> head_valid)
    else $error("second phase without queued entry");

  // Error beats always close their entry.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.last)
    else $error("error beat without last");

  // A bad format reports no address or data.
  a_format_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_BAD_FORMAT) |->
      (out_o.target_address == '0 && out_o.new_word == '0))
    else $error("format error beat carries data");
`endif

endmodule
